// ===== design/serial_framed_gpio_expander_macros.svh =====
// Assertion macros shared by the serial GPIO expander modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SERIAL_FRAMED_GPIO_EXPANDER_MACROS_SVH
`define SERIAL_FRAMED_GPIO_EXPANDER_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define SFGE_ASSERT_ALWAYS(label, clk_i, rst_ni, expr) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
		else $error("sfge: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SFGE_ASSERT_IMP(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("sfge: implication violated");

// The consequent holds in the cycle after the antecedent.
`define SFGE_ASSERT_NXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("sfge: next-cycle implication violated");

`endif

// ===== design/sfge_pkg.sv =====
// Package for the serial GPIO expander: constants, payload structs and job types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sfge_pkg;

	// Width of the pin fields and the default number of lines.
	localparam int PIN_W         = 10;
	localparam int NUM_LINES_DEF = 10;

	// Payload buffer of one frame.
	localparam int PAYLOAD_MAX = 10;
	localparam int PAY_IDX_W   = $clog2(PAYLOAD_MAX);
	localparam int PAY_CNT_W   = $clog2(PAYLOAD_MAX + 1);

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Framing bytes.
	localparam logic [7:0] SOF_BYTE = 8'hFF;
	localparam logic [7:0] EOF_BYTE = 8'hFE;

	// Command codes.
	localparam logic [7:0] CMD_MODE  = 8'h01;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_READ  = 8'h03;

	// Reply headers.
	localparam logic [7:0] HDR_MODE  = 8'h81;
	localparam logic [7:0] HDR_WRITE = 8'h82;
	localparam logic [7:0] HDR_READ  = 8'h83;
	localparam logic [7:0] HDR_POLL  = 8'h8E;

	// Setting bits kept by the mode command, and the input-line flag of an echo.
	localparam logic [3:0] MODE_KEEP_MASK = 4'hA;
	localparam logic [7:0] FLAG_INPUT     = 8'h04;

	// Request opcodes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [7:0]       rx_byte;
		logic [PIN_W-1:0] pin_levels;
	} req_t;

	typedef struct packed {
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic             last;
		logic [PIN_W-1:0] pin_drive;
		logic [PIN_W-1:0] pin_is_output;
		logic [PIN_W-1:0] switch_select;
	} rsp_t;

	// Work handed from the front to the back, one per request.
	typedef enum logic [2:0] {
		JOB_NONE,
		JOB_MODE,
		JOB_WRITE,
		JOB_READ,
		JOB_POLL
	} job_kind_t;

	typedef struct packed {
		job_kind_t                   kind;
		logic [PIN_W-1:0]            levels;
		logic [PAY_CNT_W-1:0]        count;
		logic [PAYLOAD_MAX-1:0][7:0] payload;
	} job_t;

endpackage

`default_nettype wire

// ===== design/serial_framed_gpio_expander.sv =====
// A request with no reply shows its one result with tx_valid low; a poll without changes
// first scans the lines. A mode or write frame applies its payload bytes in turn after its
// closing byte and then sends its reply; a read or a poll with changes sends a reply frame.
// Throughput: the back-end sequencer sets the rate; the front takes a request every cycle
// while the two-entry job queue has room. Reset clears frame state, settings and drive.
`default_nettype none

module serial_framed_gpio_expander #(
	parameter int NUM_LINES = sfge_pkg::NUM_LINES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  sfge_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output sfge_pkg::rsp_t rsp
);
	import sfge_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	// Deframing and classification.
	sfge_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Job queue between the two halves.
	sfge_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Command execution and reply generation.
	sfge_back #(
		.NUM_LINES (NUM_LINES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== design/sfge_front.sv =====
// Front end: deframes received bytes, buffers the payload and classifies each request.
// Depends on sfge_pkg and the assertion macros header.
`default_nettype none
`include "serial_framed_gpio_expander_macros.svh"

module sfge_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  sfge_pkg::req_t  req,
	output logic            push_valid,
	input  wire             push_ready,
	output sfge_pkg::job_t  push_job
);
	import sfge_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_CMD     = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	phase_t                      phase_q;
	logic [7:0]                  cmd_q;
	logic [PAY_CNT_W-1:0]        count_q;
	logic [PAYLOAD_MAX-1:0][7:0] store_q;

	logic      accept;
	logic      is_byte;
	logic      has_room;
	logic      store_we;
	job_kind_t cmd_kind;
	job_kind_t kind;

	// Each request becomes exactly one job, so the front stalls only on a full queue.
	assign req_ready  = push_ready;
	assign push_valid = req_valid;
	assign accept     = req_valid && push_ready;
	assign is_byte    = (req.opcode == OP_BYTE);
	assign has_room   = (count_q < PAY_CNT_W'(PAYLOAD_MAX));
	assign store_we   = accept && is_byte && (phase_q == PH_PAYLOAD) &&
		(req.rx_byte != EOF_BYTE) && has_room;

	// Decode the stored command byte.
	always_comb begin
		unique case (cmd_q)
			CMD_MODE:  cmd_kind = JOB_MODE;
			CMD_WRITE: cmd_kind = JOB_WRITE;
			CMD_READ:  cmd_kind = JOB_READ;
			default:   cmd_kind = JOB_NONE;
		endcase
	end

	// Classify the request: a closing byte runs the command, a poll between frames scans.
	always_comb begin
		kind = JOB_NONE;
		unique case (phase_q)
			PH_CMD: begin
				kind = JOB_NONE;
			end
			PH_PAYLOAD: begin
				if (is_byte && (req.rx_byte == EOF_BYTE)) begin
					kind = cmd_kind;
				end
			end
			default: begin
				if (!is_byte) begin
					kind = JOB_POLL;
				end
			end
		endcase
	end

	assign push_job = '{kind: kind, levels: req.pin_levels, count: count_q, payload: store_q};

	// Frame state machine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= '0;
			count_q <= '0;
		end else if (accept && is_byte) begin
			unique case (phase_q)
				PH_CMD: begin
					cmd_q   <= req.rx_byte;
					phase_q <= PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (req.rx_byte == EOF_BYTE) begin
						phase_q <= PH_IDLE;
					end else if (has_room) begin
						count_q <= count_q + PAY_CNT_W'(1);
					end
				end
				default: begin
					if (req.rx_byte == SOF_BYTE) begin
						phase_q <= PH_CMD;
						count_q <= '0;
					end else begin
						phase_q <= PH_IDLE;
					end
				end
			endcase
		end
	end

	// Payload buffer; entries past the count are never read.
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[count_q[PAY_IDX_W-1:0]] <= req.rx_byte;
		end
	end

	`SFGE_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= PAY_CNT_W'(PAYLOAD_MAX))

endmodule

`default_nettype wire

// ===== design/sfge_queue.sv =====
// Short job queue that decouples the front end from the back end.
// Depends on sfge_pkg.
`default_nettype none

module sfge_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push_valid,
	output logic           push_ready,
	input  sfge_pkg::job_t push_job,
	output logic           pop_valid,
	input  wire            pop_ready,
	output sfge_pkg::job_t pop_job
);
	import sfge_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== design/sfge_back.sv =====
// Back end: applies commands and polls to the line settings and sends reply frames.
// Depends on sfge_pkg and the assertion macros header.
`default_nettype none
`include "serial_framed_gpio_expander_macros.svh"

module sfge_back #(
	parameter int NUM_LINES = sfge_pkg::NUM_LINES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            pop_valid,
	output logic           pop_ready,
	input  sfge_pkg::job_t pop_job,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output sfge_pkg::rsp_t rsp
);
	import sfge_pkg::*;

	localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int KMAX   = (NUM_LINES > PAYLOAD_MAX) ? NUM_LINES : PAYLOAD_MAX;
	localparam int K_W    = $clog2(KMAX + 1);
	localparam int PAD_W  = (NUM_LINES > PIN_W) ? NUM_LINES : PIN_W;
	localparam logic [3:0] NIB_MAX = 4'(NUM_LINES);

	typedef enum logic [7:0] {
		B_IDLE = 8'b0000_0001,
		B_EXEC = 8'b0000_0010,
		B_SCAN = 8'b0000_0100,
		B_NULL = 8'b0000_1000,
		B_SOF  = 8'b0001_0000,
		B_HDR  = 8'b0010_0000,
		B_BODY = 8'b0100_0000,
		B_EOF  = 8'b1000_0000
	} bstate_t;

	bstate_t              state_q;
	job_t                 job_q;
	logic [K_W-1:0]       k_q;
	logic [3:0]           settings_q [NUM_LINES];
	logic [NUM_LINES-1:0] drive_q;
	logic [NUM_LINES-1:0] changed_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 can_emit;
	logic                 pop_fire;
	logic [7:0]           cur_byte;
	logic [3:0]           nib;
	logic                 line_ok;
	logic [LINE_W-1:0]    line_idx;
	logic [LINE_W-1:0]    k_line;
	logic [LINE_W-1:0]    rd_line;
	logic [3:0]           s_rd;
	logic [3:0]           lnum;
	logic                 pay_more;
	logic                 line_more;
	logic                 body_more;
	logic                 body_emit;
	logic [7:0]           body_byte;
	logic [7:0]           hdr_byte;
	logic [PAD_W-1:0]     lev_pad;
	logic [NUM_LINES-1:0] changed_d;
	logic [NUM_LINES-1:0] mode_v;
	logic [PAD_W-1:0]     drive_pad;
	logic [PAD_W-1:0]     mode_pad;
	logic [PAD_W-1:0]     isout_pad;
	logic                 want;
	logic                 emit;
	logic                 e_txv;
	logic [7:0]           e_byte;
	logic                 e_last;

	assign can_emit  = !rsp_valid_q || rsp_ready;
	assign pop_ready = (state_q == B_IDLE);
	assign pop_fire  = pop_valid && pop_ready;

	// Current payload byte and the line it names.
	assign cur_byte  = job_q.payload[k_q[PAY_IDX_W-1:0]];
	assign nib       = cur_byte[7:4];
	assign line_ok   = (nib != 4'd0) && (nib <= NIB_MAX);
	assign line_idx  = LINE_W'(nib - 4'd1);
	assign k_line    = k_q[LINE_W-1:0];
	assign lnum      = 4'(k_q) + 4'd1;
	assign pay_more  = (k_q < K_W'(job_q.count));
	assign line_more = (k_q < K_W'(NUM_LINES));

	// Settings read for the body and command steps: line scans use the counter, commands the payload line.
	assign rd_line = ((job_q.kind == JOB_READ) || (job_q.kind == JOB_POLL)) ? k_line : line_idx;
	assign s_rd    = settings_q[rd_line];

	// Poll compare over all input-mode lines; lines beyond the port read as low.
	assign lev_pad = PAD_W'(job_q.levels);
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			changed_d[i] = settings_q[i][3] && (lev_pad[i] != settings_q[i][0]);
			mode_v[i]    = settings_q[i][3];
		end
	end

	// Pin fields, zero above the implemented lines.
	assign drive_pad = PAD_W'(drive_q);
	assign mode_pad  = PAD_W'(mode_v);
	assign isout_pad = PAD_W'(~mode_v);

	// Reply header by job kind.
	always_comb begin
		case (job_q.kind)
			JOB_MODE:  hdr_byte = HDR_MODE;
			JOB_WRITE: hdr_byte = HDR_WRITE;
			JOB_READ:  hdr_byte = HDR_READ;
			default:   hdr_byte = HDR_POLL;
		endcase
	end

	// Body byte for the current step of the reply.
	always_comb begin
		body_more = line_more;
		body_emit = 1'b0;
		body_byte = cur_byte;
		case (job_q.kind)
			JOB_MODE: begin
				body_more = pay_more;
				body_emit = line_ok && cur_byte[3];
			end
			JOB_WRITE: begin
				body_more = pay_more;
				body_emit = line_ok;
				body_byte = s_rd[3] ? (cur_byte | FLAG_INPUT) : cur_byte;
			end
			JOB_READ: begin
				body_emit = 1'b1;
				body_byte = {lnum, s_rd[3], 2'b00, s_rd[3] ^ s_rd[0]};
			end
			default: begin
				body_emit = changed_q[k_line];
				body_byte = {lnum, 1'b1, 2'b00, ~s_rd[0]};
			end
		endcase
	end

	// Byte offered to the output register in each state.
	always_comb begin
		want   = 1'b0;
		e_txv  = 1'b1;
		e_byte = SOF_BYTE;
		e_last = 1'b0;
		unique case (state_q)
			B_NULL: begin
				want   = 1'b1;
				e_txv  = 1'b0;
				e_byte = '0;
				e_last = 1'b1;
			end
			B_SOF: begin
				want = 1'b1;
			end
			B_HDR: begin
				want   = 1'b1;
				e_byte = hdr_byte;
			end
			B_BODY: begin
				want   = body_more && body_emit;
				e_byte = body_byte;
			end
			B_EOF: begin
				want   = 1'b1;
				e_byte = EOF_BYTE;
				e_last = 1'b1;
			end
			default: begin
				want = 1'b0;
			end
		endcase
	end

	assign emit = want && can_emit;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			k_q       <= '0;
			changed_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						k_q <= '0;
						case (pop_job.kind)
							JOB_MODE:  state_q <= B_EXEC;
							JOB_WRITE: state_q <= B_EXEC;
							JOB_READ:  state_q <= B_SOF;
							JOB_POLL:  state_q <= B_SCAN;
							default:   state_q <= B_NULL;
						endcase
					end
				end
				B_EXEC: begin
					if (pay_more) begin
						k_q <= k_q + K_W'(1);
					end else begin
						k_q     <= '0;
						state_q <= B_SOF;
					end
				end
				B_SCAN: begin
					changed_q <= changed_d;
					state_q   <= (changed_d != '0) ? B_SOF : B_NULL;
				end
				B_NULL: begin
					if (can_emit) begin
						state_q <= B_IDLE;
					end
				end
				B_SOF: begin
					if (can_emit) begin
						state_q <= B_HDR;
					end
				end
				B_HDR: begin
					if (can_emit) begin
						k_q     <= '0;
						state_q <= B_BODY;
					end
				end
				B_BODY: begin
					if (!body_more) begin
						state_q <= B_EOF;
					end else if (!body_emit || can_emit) begin
						k_q <= k_q + K_W'(1);
					end
				end
				B_EOF: begin
					if (can_emit) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Job register, loaded when the queue head is taken.
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			job_q <= pop_job;
		end
	end

	// Line settings and drive values; commands update one line per cycle, a poll all at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				settings_q[i] <= '0;
			end
			drive_q <= '0;
		end else if ((state_q == B_EXEC) && pay_more && line_ok) begin
			if (job_q.kind == JOB_MODE) begin
				settings_q[line_idx] <= cur_byte[3:0] & MODE_KEEP_MASK;
				if (cur_byte[3]) begin
					drive_q[line_idx] <= 1'b0;
				end
			end else if (!s_rd[3]) begin
				settings_q[line_idx] <= {3'b000, cur_byte[0]};
				drive_q[line_idx]    <= cur_byte[0];
			end
		end else if (state_q == B_SCAN) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				if (changed_d[i]) begin
					settings_q[i][0] <= lev_pad[i];
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= '{
				tx_valid:      e_txv,
				tx_byte:       e_byte,
				last:          e_last,
				pin_drive:     drive_pad[PIN_W-1:0],
				pin_is_output: isout_pad[PIN_W-1:0],
				switch_select: mode_pad[PIN_W-1:0]
			};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SFGE_ASSERT_NXT(a_eof_last, clk, arst_n, (state_q == B_EOF) && can_emit, rsp_valid_q && rsp_q.last && (rsp_q.tx_byte == EOF_BYTE))
	`SFGE_ASSERT_IMP(a_poll_frame_changed, clk, arst_n, (state_q == B_SOF) && (job_q.kind == JOB_POLL), changed_q != '0)
	`SFGE_ASSERT_IMP(a_body_within_payload, clk, arst_n, (state_q == B_BODY) && ((job_q.kind == JOB_MODE) || (job_q.kind == JOB_WRITE)), k_q <= K_W'(job_q.count))

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the serial framed GPIO expander: directed frames, then random traffic.
// It depends on sfge_pkg and serial_framed_gpio_expander only, and holds its own line predictor.

module testbench;
	import sfge_pkg::*;

	localparam int LINES       = NUM_LINES_DEF;
	localparam int RESET_CYC   = 12;
	localparam int HOLD_CYC    = 300;
	localparam int TAIL_CYC    = 50;
	localparam int TIMEOUT_NS  = 4000000;

	// Phase of the frame decoder in the predictor.
	typedef enum logic [1:0] {
		WAIT_SOF,
		WAIT_CMD,
		TAKE_PAYLOAD
	} frame_st_t;

	typedef struct {
		req_t stim;
		bit   typed;
	} row_t;

	// The only result typed by hand: a request that causes no reply, right after reset.
	localparam rsp_t QUIET_AFTER_RESET = '{
		tx_valid: 1'b0, tx_byte: 8'h00, last: 1'b1,
		pin_drive: '0, pin_is_output: '1, switch_select: '0
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req       = '0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	// Predictor state.
	frame_st_t        frame_st = WAIT_SOF;
	logic [7:0]       cur_cmd = 8'h00;
	logic [7:0]       pay_buf [PAYLOAD_MAX] = '{default: '0};
	int               pay_cnt = 0;
	logic [3:0]       line_cfg [LINES] = '{default: '0};
	logic [PIN_W-1:0] drive_bits = '0;

	rsp_t step_out [$];
	rsp_t reply_due [$];
	bit   typed_due [$];
	req_t batch [$];
	row_t dir_rows [$];

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int n_reqs = 0;
	int n_rsps = 0;
	int n_frames = 0;
	int n_phases = 0;

	serial_framed_gpio_expander uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the results of one accepted request and advance the predictor state.
	function automatic void expander_step(input req_t r);
		logic [7:0]       replies [$];
		logic [7:0]       b;
		logic [7:0]       v;
		logic [3:0]       s;
		logic [3:0]       nib;
		logic [PIN_W-1:0] outs;
		logic [PIN_W-1:0] sws;
		int               ln;
		step_out.delete();
		if (r.opcode == OP_BYTE) begin
			case (frame_st)
				WAIT_CMD: begin
					cur_cmd = r.rx_byte;
					frame_st = TAKE_PAYLOAD;
				end
				TAKE_PAYLOAD: begin
					if (r.rx_byte != EOF_BYTE) begin
						// Bytes past the buffer size are dropped.
						if (pay_cnt < PAYLOAD_MAX) begin
							pay_buf[pay_cnt] = r.rx_byte;
							pay_cnt++;
						end
					end else begin
						frame_st = WAIT_SOF;
						if (cur_cmd == CMD_MODE || cur_cmd == CMD_WRITE) begin
							replies.push_back(SOF_BYTE);
							replies.push_back(cur_cmd == CMD_MODE ? HDR_MODE : HDR_WRITE);
							for (int k = 0; k < pay_cnt; k++) begin
								b = pay_buf[k];
								nib = b[7:4];
								// A line nibble of zero or past the last line is skipped.
								if (nib != 4'd0 && nib <= LINES) begin
									ln = nib - 1;
									if (cur_cmd == CMD_MODE) begin
										line_cfg[ln] = b[3:0] & MODE_KEEP_MASK;
										if (b[3]) begin
											drive_bits[ln] = 1'b0;
											replies.push_back(b);
										end
									end else if (!line_cfg[ln][3]) begin
										line_cfg[ln] = {3'b000, b[0]};
										drive_bits[ln] = b[0];
										replies.push_back(b);
									end else begin
										replies.push_back(b | FLAG_INPUT);
									end
								end
							end
							replies.push_back(EOF_BYTE);
						end else if (cur_cmd == CMD_READ) begin
							replies.push_back(SOF_BYTE);
							replies.push_back(HDR_READ);
							for (int i = 0; i < LINES; i++) begin
								s = line_cfg[i];
								v = {4'(i + 1), s[3], 3'b000};
								// Input lines report their value inverted.
								v[0] = s[3] ? ~s[0] : s[0];
								replies.push_back(v);
							end
							replies.push_back(EOF_BYTE);
						end
					end
				end
				default: begin
					frame_st = WAIT_SOF;
					if (r.rx_byte == SOF_BYTE) begin
						frame_st = WAIT_CMD;
						pay_cnt = 0;
					end
				end
			endcase
		end else if (frame_st == WAIT_SOF) begin
			// Poll: every input line whose level moved is stored and reported.
			replies.push_back(SOF_BYTE);
			replies.push_back(HDR_POLL);
			for (int i = 0; i < LINES; i++) begin
				s = line_cfg[i];
				if (s[3] && r.pin_levels[i] != s[0]) begin
					line_cfg[i] = {s[3:1], r.pin_levels[i]};
					v = {4'(i + 1), 4'b1000};
					v[0] = ~r.pin_levels[i];
					replies.push_back(v);
				end
			end
			if (replies.size() == 2)
				replies.delete();
			else
				replies.push_back(EOF_BYTE);
		end

		for (int i = 0; i < PIN_W; i++) begin
			outs[i] = ~line_cfg[i][3];
			sws[i] = line_cfg[i][3];
		end
		if (replies.size() == 0) begin
			step_out.push_back(rsp_t'{1'b0, 8'h00, 1'b1, drive_bits, outs, sws});
		end else begin
			foreach (replies[k])
				step_out.push_back(rsp_t'{1'b1, replies[k],
					(k == replies.size() - 1) ? 1'b1 : 1'b0, drive_bits, outs, sws});
		end
	endfunction

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Predict on each accepted request, check each accepted result against the oldest one due.
	always @(posedge clk) begin : watch
		rsp_t want;
		bit   typed;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				typed = typed_due.pop_front();
				expander_step(req);
				if (typed)
					reply_due.push_back(QUIET_AFTER_RESET);
				else
					foreach (step_out[i]) reply_due.push_back(step_out[i]);
				n_reqs++;
			end
			if (rsp_valid && rsp_ready) begin
				n_rsps++;
				if (rsp.tx_valid && rsp.last)
					n_frames++;
				if (reply_due.size() == 0) begin
					$display("%0t: no result expected, got %h", $time, rsp);
					errors++;
				end else begin
					want = reply_due.pop_front();
					compare_field("tx_valid", rsp.tx_valid, want.tx_valid);
					compare_field("tx_byte", rsp.tx_byte, want.tx_byte);
					compare_field("last", rsp.last, want.last);
					compare_field("pin_drive", rsp.pin_drive, want.pin_drive);
					compare_field("pin_is_output", rsp.pin_is_output, want.pin_is_output);
					compare_field("switch_select", rsp.switch_select, want.switch_select);
				end
			end
		end
	end

	// Result side: random stalls, or a long hold-off when the stimulus asks for one.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Offer one request and return at the edge that accepts it.
	task automatic offer_request(input req_t r, input bit typed);
		typed_due.push_back(typed);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic void add_byte(input logic [7:0] b);
		batch.push_back(req_t'{OP_BYTE, b, PIN_W'($urandom)});
	endfunction

	function automatic void add_poll();
		batch.push_back(req_t'{OP_POLL, 8'($urandom), PIN_W'($urandom)});
	endfunction

	// Payload byte that mostly names a real line.
	function automatic logic [7:0] payload_byte();
		logic [3:0] nib;
		nib = ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(LINES, 1));
		return {nib, 4'($urandom)};
	endfunction

	// Mostly well-formed frames with random content, plus polls, unknown commands and stray bytes.
	task automatic build_batch(input int n);
		int         pick;
		int         len;
		logic [7:0] cmd;
		while (batch.size() < n) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				add_byte(SOF_BYTE);
				add_byte(pick < 20 ? CMD_MODE : CMD_WRITE);
				len = ($urandom_range(7) == 0) ? $urandom_range(13, 11) : $urandom_range(10, 0);
				repeat (len) begin
					if ($urandom_range(9) == 0)
						add_poll();
					add_byte(payload_byte());
				end
				add_byte(EOF_BYTE);
			end else if (pick < 55) begin
				add_byte(SOF_BYTE);
				add_byte(CMD_READ);
				add_byte(EOF_BYTE);
			end else if (pick < 80) begin
				add_poll();
			end else if (pick < 88) begin
				cmd = 8'($urandom);
				if (cmd == CMD_MODE || cmd == CMD_WRITE || cmd == CMD_READ)
					cmd = ~cmd;
				add_byte(SOF_BYTE);
				add_byte(cmd);
				repeat ($urandom_range(3)) add_byte(payload_byte());
				add_byte(EOF_BYTE);
			end else begin
				add_byte(8'($urandom));
			end
		end
	endtask

	// One idling pattern: drain what is due, then send a fresh random batch.
	task automatic run_phase(input int n, input int idle_pct, input int stall_pct, input bit hold);
		req_valid <= 1'b0;
		@(posedge clk);
		while (reply_due.size() != 0) @(posedge clk);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		if (hold)
			hold_token++;
		n_phases++;
		build_batch(n);
		while (batch.size() != 0) offer_request(batch.pop_front(), 1'b0);
	endtask

	function automatic row_t mk(input logic op, input logic [7:0] b,
			input logic [PIN_W-1:0] lv, input bit typed);
		return '{stim: req_t'{op, b, lv}, typed: typed};
	endfunction

	initial begin
		// Directed frames: idle bytes and polls after reset, mode and write frames with
		// skipped line nibbles, a poll inside a frame, input changes, a read, an unknown command.
		dir_rows = '{
			mk(OP_BYTE, 8'h00, 10'h000, 1'b1),
			mk(OP_POLL, 8'hFF, 10'h3FF, 1'b1),
			mk(OP_BYTE, SOF_BYTE, 10'h3FF, 1'b1),
			mk(OP_BYTE, CMD_MODE, 10'h000, 1'b0),
			mk(OP_BYTE, 8'h18, 10'h000, 1'b0),
			mk(OP_BYTE, 8'hA8, 10'h000, 1'b0),
			mk(OP_BYTE, 8'h0F, 10'h000, 1'b0),
			mk(OP_BYTE, 8'hBF, 10'h000, 1'b0),
			mk(OP_BYTE, 8'h22, 10'h000, 1'b0),
			mk(OP_BYTE, EOF_BYTE, 10'h000, 1'b0),
			mk(OP_BYTE, SOF_BYTE, 10'h000, 1'b0),
			mk(OP_BYTE, CMD_WRITE, 10'h000, 1'b0),
			mk(OP_BYTE, 8'h31, 10'h000, 1'b0),
			mk(OP_POLL, 8'h00, 10'h155, 1'b0),
			mk(OP_BYTE, 8'h11, 10'h000, 1'b0),
			mk(OP_BYTE, 8'hFF, 10'h000, 1'b0),
			mk(OP_BYTE, EOF_BYTE, 10'h000, 1'b0),
			mk(OP_POLL, 8'h00, 10'h3FF, 1'b0),
			mk(OP_POLL, 8'h00, 10'h000, 1'b0),
			mk(OP_BYTE, SOF_BYTE, 10'h000, 1'b0),
			mk(OP_BYTE, CMD_READ, 10'h000, 1'b0),
			mk(OP_BYTE, EOF_BYTE, 10'h000, 1'b0),
			mk(OP_BYTE, SOF_BYTE, 10'h000, 1'b0),
			mk(OP_BYTE, 8'h07, 10'h000, 1'b0),
			mk(OP_BYTE, EOF_BYTE, 10'h000, 1'b0)
		};

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) offer_request(dir_rows[i].stim, dir_rows[i].typed);

		run_phase(16, 0, 0, 1'b0);
		run_phase(16, 81, 0, 1'b0);
		run_phase(16, 0, 81, 1'b0);
		run_phase(16, 8, 8, 1'b0);
		// Long result hold-off while requests keep coming, so the job queue backs up.
		run_phase(14, 0, 0, 1'b1);

		req_valid <= 1'b0;
		@(posedge clk);
		while (reply_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("Ran %0d requests in %0d idling phases plus directed frames.", n_reqs, n_phases);
		$display("Checked %0d results, %0d of them closing a reply frame.", n_rsps, n_frames);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results still due.", reply_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
